[design/ppc32_xer_ov_ca_flags_top_macros.svh]
// ----------------------------------------------------------------------------
// ppc32_xer_ov_ca_flags_top_macros
// assertion macros for the xer flag pipeline
// ----------------------------------------------------------------------------
`ifndef PPC32_XER_OV_CA_FLAGS_TOP_MACROS_SVH
`define PPC32_XER_OV_CA_FLAGS_TOP_MACROS_SVH

// clocked assertion, switched off while reset is held
`define XERF_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define XERF_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/xerf_pkg.sv]
// ----------------------------------------------------------------------------
// xerf_pkg
// shared types and operation codes for the xer overflow / carry flag block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package xerf_pkg;

  localparam int unsigned CmdW  = 4;
  localparam int unsigned WordW = 32;
  // operand half and partial product widths for the split multiply
  localparam int unsigned HalfW = WordW / 2;
  localparam int unsigned PartW = WordW + HalfW;

  // operation codes
  localparam logic [CmdW-1:0] CMD_ADD   = 4'd0;
  localparam logic [CmdW-1:0] CMD_ADDE  = 4'd1;
  localparam logic [CmdW-1:0] CMD_DIVW  = 4'd2;
  localparam logic [CmdW-1:0] CMD_DIVWU = 4'd3;
  localparam logic [CmdW-1:0] CMD_MULLW = 4'd4;
  localparam logic [CmdW-1:0] CMD_NEG   = 4'd5;
  localparam logic [CmdW-1:0] CMD_SUBF  = 4'd6;
  localparam logic [CmdW-1:0] CMD_SUBFC = 4'd7;
  localparam logic [CmdW-1:0] CMD_SUBFE = 4'd8;
  localparam logic [CmdW-1:0] CMD_SUBFI = 4'd9;
  localparam logic [CmdW-1:0] CMD_SRAW  = 4'd10;
  localparam logic [CmdW-1:0] CMD_SRAWI = 4'd11;

  localparam logic [WordW-1:0] SIGN_WORD = 32'h8000_0000;
  localparam logic [WordW-1:0] ALL_ONES  = 32'hFFFF_FFFF;

  // input transaction
  typedef struct packed {
    logic [CmdW-1:0]  command;
    logic [WordW-1:0] result_value;
    logic [WordW-1:0] left_operand;
    logic [WordW-1:0] right_operand;
    logic             carry_in;
  } in_t;

  // result transaction
  typedef struct packed {
    logic overflow;
    logic overflow_valid;
    logic carry_out;
    logic carry_valid;
  } out_t;

endpackage

[design/ppc32_xer_ov_ca_flags_top.sv]
// ----------------------------------------------------------------------------
// ppc32_xer_ov_ca_flags_top
// three-stage pipeline computing the xer overflow and carry bits
// ----------------------------------------------------------------------------
// usage
//   in_valid / in_stall / in_data carry one instruction per transaction:
//   command, result, both operands and the previous carry bit.
//   out_valid / out_stall / out_data return one flag transaction for each
//   input transaction, in order: ov, ov valid, ca, ca valid.
//   out_valid comes from the stage c register, so each accepted input passes
//   through stages a, b and c before its result is offered at the output.
//   throughput is one transaction per cycle while out_stall is low; the first
//   stage forms two 32x16 partial products beside the compares, the second
//   sums them and the third checks the product range and selects the flags.
//   each stage holds its own valid bit, so a bubble is filled while the
//   output waits; when out_stall is held the stages fill up behind the
//   output register and in_stall rises only once all three are occupied.
//   reset empties the pipeline; no transaction is in flight afterwards.
//   commands without meaning return all four fields as zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ppc32_xer_ov_ca_flags_top_macros.svh"

module ppc32_xer_ov_ca_flags_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  xerf_pkg::in_t in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output xerf_pkg::out_t out_data
);
  import xerf_pkg::*;

  // compares and carry terms worked out from the operands
  typedef struct packed {
    logic res_lt_a;
    logic res_eq_a;
    logic res_lt_b;
    logic res_eq_b;
    logic a_is_min;
    logic b_all_ones;
    logic b_zero;
    logic shift_ca;
    logic add_ov;
    logic sub_ov;
  } cmp_t;

  // stage a contents: compares and the two partial products
  typedef struct packed {
    logic [CmdW-1:0]  command;
    logic             carry_in;
    cmp_t             cmp;
    logic [PartW-1:0] pp_lo;
    logic [PartW-1:0] pp_hi;
  } stage_a_t;

  // stage b contents: compares and the full product
  typedef struct packed {
    logic [CmdW-1:0]    command;
    logic               carry_in;
    cmp_t               cmp;
    logic [2*WordW-1:0] product;
  } stage_b_t;

  logic     va_r, vb_r, vc_r;
  stage_a_t sa_r, sa_nxt;
  stage_b_t sb_r, sb_nxt;
  out_t     sc_r, sc_nxt;
  logic     ready_a, ready_b, ready_c;
  logic [WordW-1:0] shift_mask;

  // per-stage advance conditions
  assign ready_c = !vc_r || !out_stall;
  assign ready_b = !vb_r || ready_c;
  assign ready_a = !va_r || ready_b;
  assign in_stall = !ready_a;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      if (ready_a) va_r <= in_valid;
      if (ready_b) vb_r <= va_r;
      if (ready_c) vc_r <= vb_r;
    end
  end

  // stage a logic: compares, shift carry and partial products
  always_comb begin
    shift_mask            = ~(ALL_ONES << in_data.right_operand[4:0]);
    sa_nxt.command        = in_data.command;
    sa_nxt.carry_in       = in_data.carry_in;
    sa_nxt.cmp.res_lt_a   = in_data.result_value < in_data.left_operand;
    sa_nxt.cmp.res_eq_a   = in_data.result_value == in_data.left_operand;
    sa_nxt.cmp.res_lt_b   = in_data.result_value < in_data.right_operand;
    sa_nxt.cmp.res_eq_b   = in_data.result_value == in_data.right_operand;
    sa_nxt.cmp.a_is_min   = in_data.left_operand == SIGN_WORD;
    sa_nxt.cmp.b_all_ones = in_data.right_operand == ALL_ONES;
    sa_nxt.cmp.b_zero     = in_data.right_operand == '0;
    // bits shifted out of a negative value set the carry
    sa_nxt.cmp.shift_ca   = in_data.left_operand[WordW-1] &
                            (in_data.right_operand[5] |
                             (|(in_data.left_operand & shift_mask)));
    sa_nxt.cmp.add_ov     = ~(in_data.left_operand[WordW-1] ^
                              in_data.right_operand[WordW-1]) &
                            (in_data.left_operand[WordW-1] ^
                             in_data.result_value[WordW-1]);
    sa_nxt.cmp.sub_ov     = (in_data.left_operand[WordW-1] ^
                             in_data.right_operand[WordW-1]) &
                            ~(in_data.left_operand[WordW-1] ^
                              in_data.result_value[WordW-1]);
    // signed operand times the unsigned low half and the signed high half
    sa_nxt.pp_lo          = PartW'($signed(in_data.left_operand)) *
                            PartW'($signed({1'b0, in_data.right_operand[HalfW-1:0]}));
    sa_nxt.pp_hi          = PartW'($signed(in_data.left_operand)) *
                            PartW'($signed(in_data.right_operand[WordW-1:HalfW]));
  end

  always_ff @(posedge clk) begin
    if (ready_a && in_valid) sa_r <= sa_nxt;
  end

  // stage b logic: sum of the partial products
  always_comb begin
    sb_nxt.command  = sa_r.command;
    sb_nxt.carry_in = sa_r.carry_in;
    sb_nxt.cmp      = sa_r.cmp;
    sb_nxt.product  = {sa_r.pp_hi, {HalfW{1'b0}}} +
                      {{HalfW{sa_r.pp_lo[PartW-1]}}, sa_r.pp_lo};
  end

  always_ff @(posedge clk) begin
    if (ready_b && va_r) sb_r <= sb_nxt;
  end

  // stage c logic: product range check and per-command selection
  always_comb begin
    sc_nxt = '0;
    case (sb_r.command) inside
      CMD_ADD: begin
        sc_nxt.overflow       = sb_r.cmp.add_ov;
        sc_nxt.overflow_valid = 1'b1;
        sc_nxt.carry_out      = sb_r.cmp.res_lt_a;
        sc_nxt.carry_valid    = 1'b1;
      end
      CMD_ADDE: begin
        sc_nxt.overflow       = sb_r.cmp.add_ov;
        sc_nxt.overflow_valid = 1'b1;
        sc_nxt.carry_out      = sb_r.cmp.res_lt_a | (sb_r.carry_in & sb_r.cmp.res_eq_a);
        sc_nxt.carry_valid    = 1'b1;
      end
      CMD_DIVW: begin
        sc_nxt.overflow       = (sb_r.cmp.a_is_min & sb_r.cmp.b_all_ones) |
                                sb_r.cmp.b_zero;
        sc_nxt.overflow_valid = 1'b1;
      end
      CMD_DIVWU: begin
        sc_nxt.overflow       = sb_r.cmp.b_zero;
        sc_nxt.overflow_valid = 1'b1;
      end
      CMD_MULLW: begin
        sc_nxt.overflow       = sb_r.product[2*WordW-1:WordW] !=
                                {WordW{sb_r.product[WordW-1]}};
        sc_nxt.overflow_valid = 1'b1;
      end
      CMD_NEG: begin
        sc_nxt.overflow       = sb_r.cmp.a_is_min;
        sc_nxt.overflow_valid = 1'b1;
      end
      CMD_SUBF: begin
        sc_nxt.overflow       = sb_r.cmp.sub_ov;
        sc_nxt.overflow_valid = 1'b1;
      end
      CMD_SUBFC: begin
        sc_nxt.overflow       = sb_r.cmp.sub_ov;
        sc_nxt.overflow_valid = 1'b1;
        sc_nxt.carry_out      = sb_r.cmp.res_lt_b | sb_r.cmp.res_eq_b;
        sc_nxt.carry_valid    = 1'b1;
      end
      CMD_SUBFE: begin
        sc_nxt.overflow       = sb_r.cmp.sub_ov;
        sc_nxt.overflow_valid = 1'b1;
        sc_nxt.carry_out      = sb_r.cmp.res_lt_b | (sb_r.carry_in & sb_r.cmp.res_eq_b);
        sc_nxt.carry_valid    = 1'b1;
      end
      CMD_SUBFI: begin
        sc_nxt.carry_out      = sb_r.cmp.res_lt_b | sb_r.cmp.res_eq_b;
        sc_nxt.carry_valid    = 1'b1;
      end
      CMD_SRAW, CMD_SRAWI: begin
        sc_nxt.carry_out      = sb_r.cmp.shift_ca;
        sc_nxt.carry_valid    = 1'b1;
      end
      default: sc_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ready_c && vb_r) sc_r <= sc_nxt;
  end

  assign out_valid = vc_r;
  assign out_data  = sc_r;

  // checks
  `XERF_ASSERT(a_accept_lands, clk, rst_n, in_valid && !in_stall |=> va_r,
               "accepted transaction did not reach stage a")
  `XERF_ASSERT(a_blocked_holds, clk, rst_n,
               va_r && !ready_b |=> va_r && $stable(sa_r),
               "stage a changed while blocked")
  `XERF_ASSERT(b_blocked_holds, clk, rst_n,
               vb_r && !ready_c |=> vb_r && $stable(sb_r),
               "stage b changed while blocked")
  `XERF_ASSERT_ALWAYS(reset_empties, clk, !rst_n |=> !va_r && !vb_r && !vc_r,
                      "pipeline not empty after reset")

endmodule
